// ===== rtl/vnos_pkg.sv =====
// shared types and constants for the octave value noise block
`default_nettype none

package vnos_pkg;

  // lattice hash constants
  localparam logic [31:0] HASH_K1 = 32'd15731;
  localparam logic [31:0] HASH_K2 = 32'd789221;
  localparam logic [31:0] HASH_K3 = 32'd1376312589;

  // widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned SCALED_W = 40;  // holds coord * 2^7 exactly
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned HASH_W   = 31;

  // register depth of the hash unit and of one cell
  localparam int unsigned HASH_LAT = 4;
  localparam int unsigned CELL_LAT = HASH_LAT + 3;

  // lattice value 1.0 in q.16
  localparam logic signed [SUM_W-1:0] ONE_Q16 = 18'sd65536;

  // transaction handed from one cell to the next
  typedef struct packed {
    logic                       vld;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SUM_W-1:0]    total;
  } vnos_link_t;

endpackage : vnos_pkg

`default_nettype wire

// ===== rtl/vnos_hash.sv =====
// pipelined 32-bit integer lattice hash, at most one multiplier per stage
`default_nettype none

module vnos_hash import vnos_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [31:0]       idx_i,
  output      logic [HASH_W-1:0] hash_o
);

  logic [31:0] m0_q, m1_q, m2_q;
  logic [31:0] sq_q, p_q, r_q;

  // stage 1: mix, stage 2: square, stage 3: scale and offset, stage 4: final product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q <= (idx_i << 13) ^ idx_i;
      m1_q <= m0_q;
      sq_q <= 32'(m0_q * m0_q);
      m2_q <= m1_q;
      p_q  <= 32'(sq_q * HASH_K1) + HASH_K2;
      r_q  <= 32'(m2_q * p_q) + HASH_K3;
    end
  end

  assign hash_o = r_q[HASH_W-1:0];

endmodule : vnos_hash

`default_nettype wire

// ===== rtl/vnos_cell.sv =====
// one octave: lattice hashes, linear blend, amplitude shift and running sum
`default_nettype none

module vnos_cell import vnos_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire vnos_link_t link_i,
  output      vnos_link_t link_o
);

  logic [31:0]       idx_lo, idx_hi;
  logic [HASH_W-1:0] hash_s, hash_t;

  // lattice index is the floor of the scaled coordinate, wrapped to 32 bits
  assign idx_lo = 32'(link_i.scaled >>> FRAC_W);
  assign idx_hi = idx_lo + 32'd1;

  vnos_hash u_hash_lo (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .idx_i  (idx_lo),
    .hash_o (hash_s)
  );

  vnos_hash u_hash_hi (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .idx_i  (idx_hi),
    .hash_o (hash_t)
  );

  // side line that keeps the transaction aligned with the hash units
  vnos_link_t dly_q [HASH_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HASH_LAT; k++) begin
        dly_q[k] <= '0;
      end
    end else if (en_i) begin
      dly_q[0] <= link_i;
      for (int k = 1; k < HASH_LAT; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  // lattice values and their difference
  logic signed [SUM_W-1:0] val_s, val_t;
  assign val_s = ONE_Q16 - $signed({1'b0, hash_s[HASH_W-1:14]});
  assign val_t = ONE_Q16 - $signed({1'b0, hash_t[HASH_W-1:14]});

  vnos_link_t              l5_q, l6_q, l7_q;
  logic signed [SUM_W-1:0] s5_q, d5_q;
  logic signed [35:0]      acc6_q;

  logic signed [35:0]      acc6_d;
  logic signed [SUM_W-1:0] blend, term;
  logic [FRAC_W-1:0]       frac5;

  // blend as s + f*(t-s), kept in q.32 until the final shift
  assign frac5  = l5_q.scaled[FRAC_W-1:0];
  assign acc6_d = 36'(s5_q) * 36'sd65536 + 36'($signed({1'b0, frac5})) * 36'(d5_q);

  // floor to q.16, then amplitude shift for this octave
  assign blend = acc6_q[FRAC_W +: SUM_W];
  assign term  = blend >>> SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l5_q <= '0;
      l6_q <= '0;
      l7_q <= '0;
    end else if (en_i) begin
      l5_q <= dly_q[HASH_LAT-1];
      l6_q <= l5_q;
      l7_q.vld    <= l6_q.vld;
      l7_q.scaled <= l6_q.scaled <<< 1;
      l7_q.total  <= l6_q.total + term;
    end
  end

  // blend datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_q   <= val_s;
      d5_q   <= val_t - val_s;
      acc6_q <= acc6_d;
    end
  end

  assign link_o = l7_q;

endmodule : vnos_cell

`default_nettype wire

// ===== rtl/vnos_skid.sv =====
// output register with a skid entry, freezes the chain only when both hold data
`default_nettype none

module vnos_skid import vnos_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire logic [SUM_W-1:0] data_i,
  output      logic             en_o,
  output      logic             vld_o,
  output      logic [SUM_W-1:0] data_o,
  input  wire logic             rdy_i
);

  logic             out_vld_q, skid_vld_q;
  logic [SUM_W-1:0] out_q, skid_q;
  logic             take, push;

  assign en_o = !skid_vld_q;
  assign take = out_vld_q && rdy_i;
  assign push = en_o && vld_i;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (take) begin
          skid_vld_q <= 1'b0;
        end
      end else if (push) begin
        if (!out_vld_q || take) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_vld_q || take) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

  assign vld_o  = out_vld_q;
  assign data_o = out_q;

endmodule : vnos_skid

`default_nettype wire

// ===== rtl/value_noise_octave_sum.sv =====
// top level: chain of octave cells summing one-dimensional value noise
//
// Usage:
//   Input stream (s_axis): one signed q15.16 coordinate per transaction in
//   tdata[31:0]. Output stream (m_axis): the octave sum, signed with 16
//   fraction bits, in tdata[17:0], upper bits zero.
//   Each octave is one cell of 7 register stages (4 in the hash multiplier
//   pipeline, then difference, blend product and accumulate), and the
//   chain of cells is followed by the output register.
//   Throughput is one coordinate per cycle as long as the receiver takes
//   results; the chain and all multipliers advance together on one enable.
//   When the receiver stalls, one further result lands in a skid entry
//   behind the output register; after that the chain freezes and
//   s_axis_tready_o drops until a result is taken from the output register.
//   Reset clears all valid flags; no result is pending after reset and the
//   block accepts a coordinate in the first cycle after reset is released.
//   The block has no state across items, results come out in input order.
`default_nettype none

module value_noise_octave_sum import vnos_pkg::*; #(
  parameter int unsigned OCTAVES = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] coord
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [23:0] m_axis_tdata_o    // [17:0] noise_sum, [23:18] zero
);

  logic             en;
  logic [SUM_W-1:0] sum_out;
  vnos_link_t       link [OCTAVES+1];

  // chain entry: coordinate at octave zero scale, empty sum
  assign link[0].vld    = s_axis_tvalid_i && en;
  assign link[0].scaled = SCALED_W'($signed(s_axis_tdata_i));
  assign link[0].total  = '0;

  // one cell per octave, each doubling the coordinate for its neighbor
  for (genvar g = 0; g < OCTAVES; g++) begin : g_cell
    vnos_cell #(
      .SHIFT (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .link_i (link[g]),
      .link_o (link[g+1])
    );
  end

  // output register and skid entry
  vnos_skid u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (link[OCTAVES].vld),
    .data_i (link[OCTAVES].total),
    .en_o   (en),
    .vld_o  (m_axis_tvalid_o),
    .data_o (sum_out),
    .rdy_i  (m_axis_tready_i)
  );

  assign s_axis_tready_o = en;
  assign m_axis_tdata_o  = {6'd0, sum_out};

endmodule : value_noise_octave_sum

`default_nettype wire
